FILE: rtl/core/sgd_pkg.sv
// Shared types, constants and the month length table for the
// seconds-to-date converter. No dependencies.
`default_nettype none

package sgd_pkg;

   localparam int unsigned SEC_W = 39;

   localparam logic [SEC_W-1:0] LAST_SECOND = 39'd315537897599;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned DAYS_400Y     = 400 * 365 + 100 - 4 + 1;
   localparam int unsigned DAYS_100Y     = 100 * 365 + 25 - 1;
   localparam int unsigned DAYS_4Y       = 4 * 365 + 1;
   localparam int unsigned DAYS_1Y       = 365;

   // Quotient bits produced by each long-division pass
   localparam int unsigned DAY_STEPS  = 23;
   localparam int unsigned HOUR_STEPS = 5;
   localparam int unsigned MIN_STEPS  = 6;
   localparam int unsigned Q400_STEPS = 5;
   localparam int unsigned Q100_STEPS = 2;
   localparam int unsigned Q4_STEPS   = 5;
   localparam int unsigned Q1_STEPS   = 2;

   localparam int unsigned CNT_W = 5;
   localparam int unsigned DAYS_W = DAY_STEPS;

   // Divisor aligned with the top quotient bit of each pass
   localparam logic [SEC_W-1:0] DVS_DAY  = SEC_W'(SECS_PER_DAY)  << (DAY_STEPS - 1);
   localparam logic [SEC_W-1:0] DVS_HOUR = SEC_W'(SECS_PER_HOUR) << (HOUR_STEPS - 1);
   localparam logic [SEC_W-1:0] DVS_MIN  = SEC_W'(SECS_PER_MIN)  << (MIN_STEPS - 1);
   localparam logic [SEC_W-1:0] DVS_400Y = SEC_W'(DAYS_400Y)     << (Q400_STEPS - 1);
   localparam logic [SEC_W-1:0] DVS_100Y = SEC_W'(DAYS_100Y)     << (Q100_STEPS - 1);
   localparam logic [SEC_W-1:0] DVS_4Y   = SEC_W'(DAYS_4Y)       << (Q4_STEPS - 1);
   localparam logic [SEC_W-1:0] DVS_1Y   = SEC_W'(DAYS_1Y)       << (Q1_STEPS - 1);

   localparam logic [3:0] LAST_WALK_MONTH = 4'd11;
   localparam logic [3:0] FEBRUARY_IDX    = 4'd1;
   localparam logic [4:0] Q4_CENTURY_END  = 5'd24;
   localparam logic [1:0] Q_CLAMPED       = 2'd3;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_DAYS  = 10'b00_0000_0010,
      ST_HOUR  = 10'b00_0000_0100,
      ST_MIN   = 10'b00_0000_1000,
      ST_Q400  = 10'b00_0001_0000,
      ST_Q100  = 10'b00_0010_0000,
      ST_Q4    = 10'b00_0100_0000,
      ST_Q1    = 10'b00_1000_0000,
      ST_MONTH = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic             ge;
      logic [SEC_W-1:0] diff;
   } step_res_type;

   function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
      logic [4:0] len;
      unique case (idx)
         4'd0:         len = 5'd31;
         FEBRUARY_IDX: len = leap ? 5'd29 : 5'd28;
         4'd2:         len = 5'd31;
         4'd3:         len = 5'd30;
         4'd4:         len = 5'd31;
         4'd5:         len = 5'd30;
         4'd6:         len = 5'd31;
         4'd7:         len = 5'd31;
         4'd8:         len = 5'd30;
         4'd9:         len = 5'd31;
         4'd10:        len = 5'd30;
         4'd11:        len = 5'd31;
         default:      len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sgd_divstep.sv
// Shared compare-and-subtract unit: one restoring division step per cycle.
// Depends on sgd_pkg.
`default_nettype none

module sgd_divstep (
   input  wire logic [sgd_pkg::SEC_W-1:0] rem,
   input  wire logic [sgd_pkg::SEC_W-1:0] dvs,
   output sgd_pkg::step_res_type           res
);

   logic [sgd_pkg::SEC_W:0] wide_diff;

   // Borrow out of the extended subtraction means rem < dvs
   assign wide_diff = {1'b0, rem} - {1'b0, dvs};
   assign res.ge    = ~wide_diff[sgd_pkg::SEC_W];
   assign res.diff  = wide_diff[sgd_pkg::SEC_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/seconds_to_gregorian_date.sv
// Top level of the seconds-to-date converter: sequencer and working registers.
// Depends on sgd_pkg and sgd_divstep.
`default_nettype none

// Converts a count of seconds since 0001-01-01 00:00:00 (proleptic Gregorian)
// into year, month, day, hour, minute and second.
// Request: drive req_seconds_count and raise start; the transfer happens at a
// clock edge where start is high and busy is low. busy stays high until the
// result has been shown.
// Result: rsp_valid is high for exactly one cycle with all rsp_ fields; the
// receiver cannot stall it, so it must take the result in that cycle.
// Steps: one compare-and-subtract unit does every step. Passes of 23, 5 and
// 6 steps split off days, hours, minutes and seconds; for in-range counts
// passes of 5, 2, 5 and 2 steps split the days into years, then a walk of 1
// to 12 steps finds the month. With range_error set the year passes and the
// month walk are skipped. The next request can be taken the cycle after
// rsp_valid.
// Out of range: rsp_range_error is set and year, month and day read zero;
// hour, minute and second still give the time of day.
// Reset (synchronous, active high) returns the block to idle; an item in
// flight is dropped.

module seconds_to_gregorian_date (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [sgd_pkg::SEC_W-1:0]   req_seconds_count,
   output logic                             rsp_valid,
   output logic [13:0]                      rsp_year,
   output logic [3:0]                       rsp_month,
   output logic [4:0]                       rsp_day,
   output logic [4:0]                       rsp_hour,
   output logic [5:0]                       rsp_minute,
   output logic [5:0]                       rsp_second,
   output logic                             rsp_range_error
);

   sgd_pkg::state_type state_ff, state_in;

   logic [sgd_pkg::SEC_W-1:0]  rem_ff, rem_in;
   logic [sgd_pkg::SEC_W-1:0]  dvs_ff, dvs_in;
   logic [sgd_pkg::DAYS_W-1:0] q_ff, q_in;
   logic [sgd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [sgd_pkg::DAYS_W-1:0] days_ff, days_in;
   logic [4:0]  q400_ff, q400_in;
   logic [1:0]  q100_ff, q100_in;
   logic [4:0]  q4_ff, q4_in;
   logic        leap_ff, leap_in;
   logic        err_ff, err_in;
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [3:0]  midx_ff, midx_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;

   sgd_pkg::step_res_type     step;
   logic [sgd_pkg::SEC_W-1:0] step_dvs;
   logic [sgd_pkg::SEC_W-1:0] rem_next;
   logic [sgd_pkg::DAYS_W-1:0] q_full;
   logic [1:0]                q1_val;
   logic                      pass_end;

   assign step_dvs = (state_ff == sgd_pkg::ST_MONTH)
                   ? sgd_pkg::SEC_W'(sgd_pkg::month_len(midx_ff, leap_ff))
                   : dvs_ff;

   sgd_divstep u_step (
      .rem (rem_ff),
      .dvs (step_dvs),
      .res (step)
   );

   assign rem_next = step.ge ? step.diff : rem_ff;
   assign q_full   = {q_ff[sgd_pkg::DAYS_W-2:0], step.ge};
   assign q1_val   = q_full[1:0];
   assign pass_end = (cnt_ff == '0);

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      days_in   = days_ff;
      q400_in   = q400_ff;
      q100_in   = q100_ff;
      q4_in     = q4_ff;
      leap_in   = leap_ff;
      err_in    = err_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      midx_in   = midx_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;

      // Common step of every division pass
      if (state_ff != sgd_pkg::ST_IDLE && state_ff != sgd_pkg::ST_MONTH &&
          state_ff != sgd_pkg::ST_DONE) begin
         rem_in = rem_next;
         dvs_in = dvs_ff >> 1;
         q_in   = q_full;
         cnt_in = cnt_ff - 1'b1;
      end

      unique case (state_ff)
         sgd_pkg::ST_IDLE: begin
            if (start) begin
               rem_in   = req_seconds_count;
               err_in   = (req_seconds_count > sgd_pkg::LAST_SECOND);
               dvs_in   = sgd_pkg::DVS_DAY;
               cnt_in   = sgd_pkg::CNT_W'(sgd_pkg::DAY_STEPS - 1);
               q_in     = '0;
               state_in = sgd_pkg::ST_DAYS;
            end
         end
         sgd_pkg::ST_DAYS: begin
            if (pass_end) begin
               days_in  = q_full;
               dvs_in   = sgd_pkg::DVS_HOUR;
               cnt_in   = sgd_pkg::CNT_W'(sgd_pkg::HOUR_STEPS - 1);
               q_in     = '0;
               state_in = sgd_pkg::ST_HOUR;
            end
         end
         sgd_pkg::ST_HOUR: begin
            if (pass_end) begin
               hour_in  = q_full[4:0];
               dvs_in   = sgd_pkg::DVS_MIN;
               cnt_in   = sgd_pkg::CNT_W'(sgd_pkg::MIN_STEPS - 1);
               q_in     = '0;
               state_in = sgd_pkg::ST_MIN;
            end
         end
         sgd_pkg::ST_MIN: begin
            if (pass_end) begin
               minute_in = q_full[5:0];
               second_in = rem_next[5:0];
               if (err_ff) begin
                  state_in = sgd_pkg::ST_DONE;
               end else begin
                  rem_in   = sgd_pkg::SEC_W'(days_ff);
                  dvs_in   = sgd_pkg::DVS_400Y;
                  cnt_in   = sgd_pkg::CNT_W'(sgd_pkg::Q400_STEPS - 1);
                  q_in     = '0;
                  state_in = sgd_pkg::ST_Q400;
               end
            end
         end
         sgd_pkg::ST_Q400: begin
            if (pass_end) begin
               q400_in  = q_full[4:0];
               dvs_in   = sgd_pkg::DVS_100Y;
               cnt_in   = sgd_pkg::CNT_W'(sgd_pkg::Q100_STEPS - 1);
               q_in     = '0;
               state_in = sgd_pkg::ST_Q100;
            end
         end
         sgd_pkg::ST_Q100: begin
            // Two quotient bits saturate at 3, which is the clamp on centuries
            if (pass_end) begin
               q100_in  = q_full[1:0];
               dvs_in   = sgd_pkg::DVS_4Y;
               cnt_in   = sgd_pkg::CNT_W'(sgd_pkg::Q4_STEPS - 1);
               q_in     = '0;
               state_in = sgd_pkg::ST_Q4;
            end
         end
         sgd_pkg::ST_Q4: begin
            if (pass_end) begin
               q4_in    = q_full[4:0];
               dvs_in   = sgd_pkg::DVS_1Y;
               cnt_in   = sgd_pkg::CNT_W'(sgd_pkg::Q1_STEPS - 1);
               q_in     = '0;
               state_in = sgd_pkg::ST_Q1;
            end
         end
         sgd_pkg::ST_Q1: begin
            if (pass_end) begin
               year_in  = 14'(q400_ff) * 14'd400 + 14'(q100_ff) * 14'd100
                        + 14'(q4_ff) * 14'd4 + 14'(q1_val) + 14'd1;
               // Year divisible by 4 when q1 is 3; a century year only when
               // the 4-year count also closes the century
               leap_in  = (q1_val == sgd_pkg::Q_CLAMPED) &&
                          ((q4_ff != sgd_pkg::Q4_CENTURY_END) ||
                           (q100_ff == sgd_pkg::Q_CLAMPED));
               month_in = 4'd1;
               midx_in  = '0;
               state_in = sgd_pkg::ST_MONTH;
            end
         end
         sgd_pkg::ST_MONTH: begin
            // Remainder is the zero-based day of year; advance while it covers a month, up to December
            if (midx_ff != sgd_pkg::LAST_WALK_MONTH && step.ge) begin
               rem_in   = step.diff;
               month_in = month_ff + 1'b1;
               midx_in  = midx_ff + 1'b1;
            end else begin
               day_in   = rem_ff[4:0] + 5'd1;
               state_in = sgd_pkg::ST_DONE;
            end
         end
         sgd_pkg::ST_DONE: begin
            state_in = sgd_pkg::ST_IDLE;
         end
         default: begin
            state_in = sgd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      days_ff   <= days_in;
      q400_ff   <= q400_in;
      q100_ff   <= q100_in;
      q4_ff     <= q4_in;
      leap_ff   <= leap_in;
      err_ff    <= err_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      midx_ff   <= midx_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
   end

   assign busy            = (state_ff != sgd_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == sgd_pkg::ST_DONE);
   assign rsp_range_error = err_ff;
   assign rsp_year        = err_ff ? '0 : year_ff;
   assign rsp_month       = err_ff ? '0 : month_ff;
   assign rsp_day         = err_ff ? '0 : day_ff;
   assign rsp_hour        = hour_ff;
   assign rsp_minute      = minute_ff;
   assign rsp_second      = second_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sgd_checker.sv
// Port-level checks for the seconds-to-date converter, bound to the top level.
// Depends on seconds_to_gregorian_date's ports only.
`default_nettype none

module sgd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [13:0] rsp_year,
   input wire logic [3:0]  rsp_month,
   input wire logic [4:0]  rsp_day,
   input wire logic        rsp_range_error
);

   // Strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_transfer_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("transfer did not start a conversion");

   a_release_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (busy ##1 !busy))
      else $error("block not released after result");

   a_error_zero_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |->
         (rsp_year == 14'd0 && rsp_month == 4'd0 && rsp_day == 5'd0))
      else $error("date fields not cleared on range error");

   a_valid_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_range_error) |->
         (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1 &&
          rsp_year >= 14'd1 && rsp_year <= 14'd9999))
      else $error("date out of calendar range");

endmodule

bind seconds_to_gregorian_date sgd_checker u_sgd_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_year        (rsp_year),
   .rsp_month       (rsp_month),
   .rsp_day         (rsp_day),
   .rsp_range_error (rsp_range_error)
);

`default_nettype wire
